// ===== hdl/pdfs_pkg.sv =====
// package for the parafoil deploy and flare sequencer: codes, widths and layouts
`timescale 1ns / 1ps

package pdfs_pkg;

  // number of pull and release pumps after deployment
  localparam int unsigned PUMP_COUNT = 2;
  localparam logic [3:0] PUMP_COUNT_W = 4'(PUMP_COUNT);
  localparam logic [3:0] PUMP_IDX_MAX = 4'd15;

  localparam int unsigned TMR_W = 20;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned IN_DATA_W = 56;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // phase codes
  localparam logic [2:0] PH_READY   = 3'd0;
  localparam logic [2:0] PH_DEPLOY  = 3'd1;
  localparam logic [2:0] PH_PULL    = 3'd2;
  localparam logic [2:0] PH_RELEASE = 3'd3;
  localparam logic [2:0] PH_GUIDED  = 3'd4;
  localparam logic [2:0] PH_FLARE   = 3'd5;
  localparam logic [2:0] PH_LANDED  = 3'd6;

  // servo modes
  localparam logic [1:0] SM_NEUTRAL = 2'd0;
  localparam logic [1:0] SM_PUMP    = 2'd1;
  localparam logic [1:0] SM_FLARE   = 2'd2;
  localparam logic [1:0] SM_GUIDED  = 2'd3;

  // commands
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_DEPLOY  = 3'd1;
  localparam logic [2:0] CMD_STOPPED = 3'd2;
  localparam logic [2:0] CMD_LANDING = 3'd3;
  localparam logic [2:0] CMD_SAMPLE  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_PULL_WAIT      = 3'd0;
  localparam logic [2:0] REG_DEPLOY_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_PUMP_HOLD      = 3'd2;
  localparam logic [2:0] REG_PUMP_REST      = 3'd3;
  localparam logic [2:0] REG_FLARE_ENABLE   = 3'd4;
  localparam logic [2:0] REG_FLARE_ALT      = 3'd5;
  localparam logic [2:0] REG_FLARE_CONF     = 3'd6;
  localparam logic [2:0] REG_FLARE_DUR      = 3'd7;

  typedef struct packed {
    logic [1:0]         pad;
    logic [7:0]         low_count;
    logic signed [15:0] right_drive;
    logic signed [15:0] left_drive;
    logic               servo_enabled;
    logic [1:0]         servo_mode;
    logic [2:0]         phase;
  } result_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic signed [15:0] guide_right;
    logic signed [15:0] guide_left;
    logic signed [15:0] ground_height_dm;
    logic               inside_map;
    logic               servos_still;
  } sample_t;

endpackage

// ===== hdl/parafoil_deploy_flare_sequencer.sv =====
// top level of the parafoil deploy and flare sequencer
`timescale 1ns / 1ps

// Parafoil deploy and flare sequencer. One word in gives one word out, and a new word can be
// taken every clock cycle while the skid register is empty: the whole state update is one
// pass of compare and count logic (two 20-bit down counters, an 8-bit saturating counter,
// one 16-bit signed compare) between the state registers and the result or skid register. A
// two-deep output stage (result register plus skid register) lets the block keep taking words
// while a result waits; s_axis_tready drops only when both are full. The command travels in
// s_axis_tuser. The phase goes ready, deployment, pull, release (pull/release repeated per
// pump), guided, flare and landed. Ticks are millisecond words; a timer armed with 0 or 1
// expires on the first tick. Configuration must be written through cfg_we_i / cfg_addr_i /
// cfg_wdata_i only while the block is idle; the block itself does not enforce this.
module parafoil_deploy_flare_sequencer
  import pdfs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // servos_still, inside_map, ground_height_dm, guide_left, guide_right, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [CMD_W-1:0]      s_axis_tuser,
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // phase, servo_mode, servo_enabled, left_drive, right_drive, low_count, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // configuration registers
  logic [TMR_W-1:0]   pull_wait_q, deploy_timeout_q, pump_hold_q, pump_rest_q, flare_dur_q;
  logic               flare_en_q;
  logic signed [15:0] flare_alt_q;
  logic [7:0]         flare_conf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pull_wait_q      <= '0;
      deploy_timeout_q <= '0;
      pump_hold_q      <= '0;
      pump_rest_q      <= '0;
      flare_en_q       <= 1'b1;
      flare_alt_q      <= '0;
      flare_conf_q     <= 8'd1;
      flare_dur_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PULL_WAIT:      pull_wait_q      <= cfg_wdata_i;
        REG_DEPLOY_TIMEOUT: deploy_timeout_q <= cfg_wdata_i;
        REG_PUMP_HOLD:      pump_hold_q      <= cfg_wdata_i;
        REG_PUMP_REST:      pump_rest_q      <= cfg_wdata_i;
        REG_FLARE_ENABLE:   flare_en_q       <= cfg_wdata_i[0];
        REG_FLARE_ALT:      flare_alt_q      <= cfg_wdata_i[15:0];
        REG_FLARE_CONF:     flare_conf_q     <= cfg_wdata_i[7:0];
        REG_FLARE_DUR:      flare_dur_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [2:0]         phase_q, phase_d;
  logic [1:0]         mode_q, mode_d;
  logic               servo_on_q, servo_on_d;
  logic [TMR_W-1:0]   ph_tmr_q, ph_tmr_d;
  logic               ph_armed_q, ph_armed_d;
  logic [TMR_W-1:0]   dp_tmr_q, dp_tmr_d;
  logic               dp_armed_q, dp_armed_d;
  logic [3:0]         pump_idx_q, pump_idx_d;
  logic [7:0]         low_cnt_q, low_cnt_d;
  logic signed [15:0] left_q, left_d;
  logic signed [15:0] right_q, right_d;

  // output stage
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  result_t result;

  logic    in_accept;
  sample_t smp;

  assign s_axis_tready = !skid_valid_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign smp           = s_axis_tdata;

  always_comb begin
    logic       dp_fire;
    logic       ph_fire;
    logic [7:0] low_next;

    phase_d    = phase_q;
    mode_d     = mode_q;
    servo_on_d = servo_on_q;
    ph_tmr_d   = ph_tmr_q;
    ph_armed_d = ph_armed_q;
    dp_tmr_d   = dp_tmr_q;
    dp_armed_d = dp_armed_q;
    pump_idx_d = pump_idx_q;
    low_cnt_d  = low_cnt_q;
    left_d     = left_q;
    right_d    = right_q;
    dp_fire    = 1'b0;
    ph_fire    = 1'b0;
    low_next   = low_cnt_q;

    if (in_accept) begin
      case (s_axis_tuser)
        CMD_TICK: begin
          // count down, expire at zero
          if (dp_armed_q) begin
            if (dp_tmr_q != '0) dp_tmr_d = dp_tmr_q - 1'b1;
            dp_fire = (dp_tmr_q <= TMR_W'(1));
            if (dp_fire) dp_armed_d = 1'b0;
          end
          if (ph_armed_q) begin
            if (ph_tmr_q != '0) ph_tmr_d = ph_tmr_q - 1'b1;
            ph_fire = (ph_tmr_q <= TMR_W'(1));
            if (ph_fire) ph_armed_d = 1'b0;
          end
          if (dp_fire && (phase_q inside {PH_DEPLOY, PH_PULL, PH_RELEASE})) begin
            // deploy timeout wins; pull keeps pump angles until the first sample
            if (phase_q != PH_PULL) mode_d = SM_NEUTRAL;
            phase_d    = PH_GUIDED;
            ph_armed_d = 1'b0;
            dp_armed_d = 1'b0;
          end else if (ph_fire) begin
            case (phase_q)
              PH_DEPLOY: begin
                mode_d = SM_NEUTRAL;
                if (PUMP_COUNT == 0) begin
                  phase_d    = PH_GUIDED;
                  dp_armed_d = 1'b0;
                end else begin
                  phase_d = PH_PULL;
                  mode_d  = SM_PUMP;
                end
              end
              PH_PULL: begin
                phase_d = PH_RELEASE;
                mode_d  = SM_NEUTRAL;
              end
              PH_RELEASE: begin
                mode_d = SM_NEUTRAL;
                if (pump_idx_q >= PUMP_COUNT_W || PUMP_COUNT == 0) begin
                  phase_d    = PH_GUIDED;
                  dp_armed_d = 1'b0;
                end else begin
                  phase_d = PH_PULL;
                  mode_d  = SM_PUMP;
                end
              end
              PH_FLARE: begin
                mode_d     = SM_NEUTRAL;
                phase_d    = PH_LANDED;
                servo_on_d = 1'b0;
              end
              default: ;
            endcase
          end
        end
        CMD_DEPLOY: begin
          if (phase_q == PH_READY) begin
            phase_d    = PH_DEPLOY;
            servo_on_d = 1'b1;
            ph_tmr_d   = pull_wait_q;
            ph_armed_d = 1'b1;
            dp_tmr_d   = deploy_timeout_q;
            dp_armed_d = 1'b1;
          end
        end
        CMD_STOPPED: begin
          // repeated reports while the phase timer runs are dropped
          if (smp.servos_still && !ph_armed_q) begin
            if (phase_q == PH_PULL) begin
              ph_tmr_d   = pump_hold_q;
              ph_armed_d = 1'b1;
            end else if (phase_q == PH_RELEASE) begin
              if (pump_idx_q != PUMP_IDX_MAX) pump_idx_d = pump_idx_q + 1'b1;
              ph_tmr_d   = pump_rest_q;
              ph_armed_d = 1'b1;
            end
          end
        end
        CMD_LANDING: begin
          if (phase_q == PH_GUIDED || phase_q == PH_FLARE) begin
            phase_d    = PH_LANDED;
            servo_on_d = 1'b0;
            ph_armed_d = 1'b0;
          end
        end
        CMD_SAMPLE: begin
          if (phase_q == PH_GUIDED) begin
            left_d  = smp.guide_left;
            right_d = smp.guide_right;
            mode_d  = SM_GUIDED;
            if (flare_en_q && smp.inside_map) begin
              if (smp.ground_height_dm <= flare_alt_q) begin
                low_next = (low_cnt_q == 8'hFF) ? low_cnt_q : low_cnt_q + 1'b1;
              end else begin
                low_next = '0;
              end
              low_cnt_d = low_next;
              if (low_next >= flare_conf_q) begin
                phase_d    = PH_FLARE;
                mode_d     = SM_FLARE;
                ph_tmr_d   = flare_dur_q;
                ph_armed_d = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_READY;
      mode_q     <= SM_NEUTRAL;
      servo_on_q <= 1'b0;
      ph_tmr_q   <= '0;
      ph_armed_q <= 1'b0;
      dp_tmr_q   <= '0;
      dp_armed_q <= 1'b0;
      pump_idx_q <= '0;
      low_cnt_q  <= '0;
      left_q     <= '0;
      right_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      mode_q     <= mode_d;
      servo_on_q <= servo_on_d;
      ph_tmr_q   <= ph_tmr_d;
      ph_armed_q <= ph_armed_d;
      dp_tmr_q   <= dp_tmr_d;
      dp_armed_q <= dp_armed_d;
      pump_idx_q <= pump_idx_d;
      low_cnt_q  <= low_cnt_d;
      left_q     <= left_d;
      right_q    <= right_d;
    end
  end

  // result word carries the state after this word
  always_comb begin
    result               = '0;
    result.phase         = phase_d;
    result.servo_mode    = mode_d;
    result.servo_enabled = servo_on_d;
    result.left_drive    = left_d;
    result.right_drive   = right_d;
    result.low_count     = low_cnt_d;
  end

  // output register plus skid register
  logic out_load;
  assign out_load = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (in_accept) out_q <= result;
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // servos are powered exactly between deployment and landed
  a_servo_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    servo_on_q == (phase_q != PH_READY && phase_q != PH_LANDED))
    else $error("servo power out of step with phase");

  // skid register only fills behind a full output register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word without output word");

  // deploy timeout runs only through deployment and pumping
  a_deploy_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_armed_q |-> (phase_q == PH_DEPLOY || phase_q == PH_PULL || phase_q == PH_RELEASE))
    else $error("deploy timer armed outside deployment");

  // phase timer never runs in ready, guided or landed
  a_phase_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_armed_q |-> (phase_q != PH_READY && phase_q != PH_GUIDED && phase_q != PH_LANDED))
    else $error("phase timer armed in untimed phase");

endmodule

// ===== verif/tb_parafoil_deploy_flare_sequencer.sv =====
// self-checking testbench for the parafoil deploy and flare sequencer
`timescale 1ns / 1ps

module tb_parafoil_deploy_flare_sequencer;
  import pdfs_pkg::*;

  // clock, reset and block ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = REG_PULL_WAIT;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // servos_still, inside_map, ground_height_dm, guide_left, guide_right, zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // command
  logic [CMD_W-1:0]      s_axis_tuser = CMD_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // phase, servo_mode, servo_enabled, left_drive, right_drive, low_count, zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // random gaps on the input side and back-pressure on the result side
  logic send_idle = 1'b1;
  logic recv_idle = 1'b1;

  // status words still owed by the block, oldest first
  result_t due_status[$];
  result_t seen_word;
  result_t want_word;
  int      mismatch_count = 0;

  // mirror of the sequencer state
  logic [2:0]         seq_phase = PH_READY;
  logic [1:0]         seq_mode = SM_NEUTRAL;
  logic               seq_servo_on = 1'b0;
  logic [19:0]        phase_ticks = '0;
  logic               phase_armed = 1'b0;
  logic [19:0]        deploy_ticks = '0;
  logic               deploy_armed = 1'b0;
  logic [3:0]         pumps_done = '0;
  logic [7:0]         low_run = '0;
  logic signed [15:0] held_left = '0;
  logic signed [15:0] held_right = '0;

  // mirror of the register file, at reset values
  logic [19:0]        pull_wait = '0;
  logic [19:0]        deploy_timeout = '0;
  logic [19:0]        pump_hold = '0;
  logic [19:0]        pump_rest = '0;
  logic               flare_on = 1'b1;
  logic signed [15:0] flare_alt = '0;
  logic [7:0]         flare_conf = 8'd1;
  logic [19:0]        flare_duration = '0;

  parafoil_deploy_flare_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // sequencer mirror
  // ---------------------------------------------------------------------------

  // guided descent drops both timers
  function automatic void go_guided();
    seq_phase = PH_GUIDED;
    phase_armed = 1'b0;
    deploy_armed = 1'b0;
  endfunction

  // next pump pull, or straight to guided when there are no pumps
  function automatic void go_pull();
    phase_armed = 1'b0;
    if (PUMP_COUNT == 0) begin
      go_guided();
    end else begin
      seq_phase = PH_PULL;
      seq_mode = SM_PUMP;
    end
  endfunction

  // one accepted word in, the status word it leads to out
  function automatic result_t flight_step(input logic [2:0] cmd, input sample_t f);
    result_t st;
    logic    deploy_fire;
    logic    phase_fire;
    deploy_fire = 1'b0;
    phase_fire = 1'b0;
    case (cmd)
      CMD_TICK: begin
        // armed timers count down and fire on reaching zero, so 0 and 1 both fire now
        if (deploy_armed) begin
          if (deploy_ticks != '0) deploy_ticks--;
          if (deploy_ticks == '0) begin
            deploy_fire = 1'b1;
            deploy_armed = 1'b0;
          end
        end
        if (phase_armed) begin
          if (phase_ticks != '0) phase_ticks--;
          if (phase_ticks == '0) begin
            phase_fire = 1'b1;
            phase_armed = 1'b0;
          end
        end
        // deploy timeout beats the phase timer; pull keeps pump angles into guided
        if (deploy_fire && (seq_phase == PH_DEPLOY || seq_phase == PH_PULL ||
                            seq_phase == PH_RELEASE)) begin
          if (seq_phase != PH_PULL) seq_mode = SM_NEUTRAL;
          go_guided();
        end else if (phase_fire) begin
          case (seq_phase)
            PH_DEPLOY: begin
              seq_mode = SM_NEUTRAL;
              go_pull();
            end
            PH_PULL: begin
              seq_phase = PH_RELEASE;
              seq_mode = SM_NEUTRAL;
            end
            PH_RELEASE: begin
              seq_mode = SM_NEUTRAL;
              if (pumps_done >= PUMP_COUNT_W) go_guided();
              else go_pull();
            end
            PH_FLARE: begin
              seq_mode = SM_NEUTRAL;
              seq_phase = PH_LANDED;
              seq_servo_on = 1'b0;
            end
            default: ;
          endcase
        end
      end
      CMD_DEPLOY: begin
        if (seq_phase == PH_READY) begin
          seq_phase = PH_DEPLOY;
          seq_servo_on = 1'b1;
          phase_ticks = pull_wait;
          phase_armed = 1'b1;
          deploy_ticks = deploy_timeout;
          deploy_armed = 1'b1;
        end
      end
      CMD_STOPPED: begin
        // a still report while a phase timer runs is dropped
        if (f.servos_still && !phase_armed) begin
          if (seq_phase == PH_PULL) begin
            phase_ticks = pump_hold;
            phase_armed = 1'b1;
          end else if (seq_phase == PH_RELEASE) begin
            if (pumps_done != PUMP_IDX_MAX) pumps_done++;
            phase_ticks = pump_rest;
            phase_armed = 1'b1;
          end
        end
      end
      CMD_LANDING: begin
        if (seq_phase == PH_GUIDED || seq_phase == PH_FLARE) begin
          seq_phase = PH_LANDED;
          seq_servo_on = 1'b0;
          phase_armed = 1'b0;
        end
      end
      CMD_SAMPLE: begin
        if (seq_phase == PH_GUIDED) begin
          held_left = f.guide_left;
          held_right = f.guide_right;
          seq_mode = SM_GUIDED;
          if (flare_on && f.inside_map) begin
            if (f.ground_height_dm <= flare_alt) begin
              if (low_run != 8'hFF) low_run++;
            end else begin
              low_run = '0;
            end
            if (low_run >= flare_conf) begin
              seq_phase = PH_FLARE;
              seq_mode = SM_FLARE;
              phase_ticks = flare_duration;
              phase_armed = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    st = '0;
    st.phase = seq_phase;
    st.servo_mode = seq_mode;
    st.servo_enabled = seq_servo_on;
    st.left_drive = held_left;
    st.right_drive = held_right;
    st.low_count = low_run;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // 16-bit value that favors the extremes
  function automatic logic [15:0] any16();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // short timer setting, with 0 and 1 well represented
  function automatic logic [19:0] short_ticks();
    if ($urandom_range(3) == 0) return 20'($urandom_range(1));
    return 20'($urandom_range(2, 12));
  endfunction

  function automatic sample_t fields(input logic still, input logic inmap,
                                     input logic [15:0] h, input logic [15:0] l,
                                     input logic [15:0] r);
    sample_t s;
    s = '0;
    s.servos_still = still;
    s.inside_map = inmap;
    s.ground_height_dm = h;
    s.guide_left = l;
    s.guide_right = r;
    return s;
  endfunction

  function automatic sample_t random_fields();
    return fields(1'($urandom), 1'($urandom), any16(), any16(), any16());
  endfunction

  // any command code, unused ones included, except up to two excluded codes
  function automatic logic [2:0] stray_cmd(input int ban_a, input int ban_b);
    logic [2:0] c;
    do c = 3'($urandom_range(7)); while (int'(c) == ban_a || int'(c) == ban_b);
    return c;
  endfunction

  // guidance sample with heights clustered around the flare altitude; an in-map
  // sample that would reach the confidence count is moved off the map
  function automatic sample_t guided_sample();
    sample_t    s;
    int         h;
    int         pick;
    logic [7:0] run_next;
    s = random_fields();
    s.inside_map = ($urandom_range(99) < 85);
    pick = $urandom_range(99);
    h = int'(s.ground_height_dm);
    if (pick < 55) h = int'(flare_alt) - int'($urandom_range(0, 300));
    else if (pick < 65) h = int'(flare_alt);
    else if (pick < 90) h = int'(flare_alt) + int'($urandom_range(1, 300));
    if (h < -32768) h = -32768;
    if (h > 32767) h = 32767;
    s.ground_height_dm = 16'(h);
    if (flare_on && s.inside_map) begin
      if (s.ground_height_dm <= flare_alt) run_next = (low_run == 8'hFF) ? low_run : low_run + 8'd1;
      else run_next = '0;
      if (run_next >= flare_conf) s.inside_map = 1'b0;
    end
    return s;
  endfunction

  // one word into the block; tvalid stays high between back-to-back words
  task automatic send_word(input logic [2:0] cmd, input sample_t f);
    while (send_idle && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= f;
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    due_status.push_back(flight_step(cmd, f));
  endtask

  // stop sending and wait until every status word is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (due_status.size() != 0);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // full register set; only called with the block idle
  task automatic set_config(input logic [19:0] dly, input logic [19:0] tmo,
                            input logic [19:0] hold, input logic [19:0] rest,
                            input logic fen, input logic [15:0] alt,
                            input logic [7:0] conf, input logic [19:0] dur);
    write_reg(REG_PULL_WAIT, dly);
    write_reg(REG_DEPLOY_TIMEOUT, tmo);
    write_reg(REG_PUMP_HOLD, hold);
    write_reg(REG_PUMP_REST, rest);
    write_reg(REG_FLARE_ENABLE, {19'd0, fen});
    write_reg(REG_FLARE_ALT, {4'd0, alt});
    write_reg(REG_FLARE_CONF, {12'd0, conf});
    write_reg(REG_FLARE_DUR, dur);
    cfg_we_i <= 1'b0;
    pull_wait = dly;
    deploy_timeout = tmo;
    pump_hold = hold;
    pump_rest = rest;
    flare_on = fen;
    flare_alt = alt;
    flare_conf = conf;
    flare_duration = dur;
  endtask

  // guided descent: mostly samples, some words that guided ignores
  task automatic descend(input int n);
    repeat (n) begin
      if ($urandom_range(99) < 10) send_word(stray_cmd(CMD_LANDING, CMD_SAMPLE), random_fields());
      else send_word(CMD_SAMPLE, guided_sample());
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values, and every command but deploy is ignored while ready
  task automatic test_ready_words();
    send_word(CMD_TICK, fields(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_word(CMD_STOPPED, fields(1'b1, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_word(CMD_STOPPED, fields(1'b0, 1'b0, 16'h8000, 16'h7FFF, 16'h8000));
    send_word(CMD_LANDING, fields(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // samples before deployment must not touch the held drives
    send_word(CMD_SAMPLE, fields(1'b1, 1'b1, 16'h8000, 16'h7FFF, 16'h8000));
    send_word(CMD_SAMPLE, fields(1'b0, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF));
    // unused command codes
    for (int c = int'(CMD_SAMPLE) + 1; c < 8; c++) begin
      send_word(3'(c), fields(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    end
    repeat (8) send_word(stray_cmd(CMD_DEPLOY, CMD_DEPLOY), random_fields());
    settle();
  endtask

  // deployment, pump pulls and releases, or the deploy timeout cutting them short
  task automatic test_pump_sequence();
    int unsigned  plan;
    int           r;
    logic [19:0]  dly;
    logic [19:0]  tmo;
    sample_t      s;
    plan = $urandom_range(2);
    dly = short_ticks();
    case (plan)
      0: tmo = 20'hFFFFF;                      // pumps finish long before the timeout
      1: tmo = 20'($urandom_range(4, 60));     // timeout lands somewhere in the pumps
      default: begin
        // both timers fire on the same tick: timeout wins
        tmo = dly;
        if ($urandom_range(1)) begin
          dly = '0;
          tmo = 20'd1;
        end
      end
    endcase
    set_config(dly, tmo, short_ticks(), short_ticks(), 1'b1, 16'h0000, 8'd1, '0);
    send_word(CMD_DEPLOY, random_fields());
    while (seq_phase != PH_GUIDED) begin
      r = $urandom_range(99);
      if (r < 15) begin
        send_word(stray_cmd(-1, -1), random_fields());
      end else if (r < 50) begin
        // stop reports, some not still and some landing while a timer runs
        s = random_fields();
        s.servos_still = ($urandom_range(3) != 0);
        send_word(CMD_STOPPED, s);
      end else begin
        send_word(CMD_TICK, random_fields());
      end
    end
    settle();
  endtask

  // guided descent under several flare settings, counter driven deep
  task automatic test_guided_descent();
    // flare detection off: samples only refresh the held drives
    set_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0, any16(),
               8'($urandom_range(1, 255)), 20'hFFFFF);
    descend(250);
    settle();
    // only the lowest height counts
    set_config('0, '0, '0, '0, 1'b1, 16'h8000, 8'd255, '0);
    descend(200);
    settle();
    // every height counts; one long run with no gaps on either side
    set_config(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom), 1'b1, 16'h7FFF,
               8'd255, 20'($urandom));
    send_idle = 1'b0;
    recv_idle = 1'b0;
    descend(350);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    settle();
    // low confidence; the sender holds off mid-run until all status is back
    set_config(short_ticks(), short_ticks(), short_ticks(), short_ticks(), 1'b1, any16(),
               8'($urandom_range(2, 40)), short_ticks());
    descend(180);
    settle();
    descend(170);
    settle();
    set_config(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom), 1'b1,
               16'($urandom_range(0, 600) - 300), 8'($urandom_range(100, 255)),
               20'($urandom));
    descend(300);
    settle();
  endtask

  // flare and landing: timed flare, landing detected in flare, or in guided
  task automatic test_flare_and_landing();
    int unsigned plan;
    int          h;
    int          n;
    logic [7:0]  conf;
    sample_t     s;
    plan = $urandom_range(2);
    // confidence zero flares on any in-map sample
    conf = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
    set_config(short_ticks(), short_ticks(), short_ticks(), short_ticks(), 1'b1, any16(), conf,
               (plan == 0) ? short_ticks() : 20'hFFFFF);
    if (plan == 2) begin
      descend(20);
      send_word(CMD_LANDING, random_fields());
    end else begin
      while (seq_phase == PH_GUIDED) begin
        s = random_fields();
        s.inside_map = 1'b1;
        h = int'(flare_alt) - int'($urandom_range(0, 50));
        if (h < -32768) h = -32768;
        s.ground_height_dm = 16'(h);
        send_word(CMD_SAMPLE, s);
      end
      n = 0;
      while (seq_phase == PH_FLARE) begin
        if (plan == 1 && n >= 40) send_word(CMD_LANDING, random_fields());
        else if ($urandom_range(99) < 30)
          send_word(stray_cmd(CMD_LANDING, CMD_LANDING), random_fields());
        else send_word(CMD_TICK, random_fields());
        n++;
      end
    end
    // landed holds whatever comes
    repeat (30) send_word(stray_cmd(-1, -1), random_fields());
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready <= !(recv_idle && ($urandom_range(99) < 32));
  end

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // each status word against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_word = m_axis_tdata;
      if (due_status.size() == 0) begin
        mismatch_count++;
        $display("%0t: status word %h expected none, got one", $time, m_axis_tdata);
      end else begin
        want_word = due_status.pop_front();
        check_field("phase", 16'(want_word.phase), 16'(seen_word.phase));
        check_field("servo_mode", 16'(want_word.servo_mode), 16'(seen_word.servo_mode));
        check_field("servo_enabled", 16'(want_word.servo_enabled),
                    16'(seen_word.servo_enabled));
        check_field("left_drive", want_word.left_drive, seen_word.left_drive);
        check_field("right_drive", want_word.right_drive, seen_word.right_drive);
        check_field("low_count", 16'(want_word.low_count), 16'(seen_word.low_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ready_words();
    test_pump_sequence();
    test_guided_descent();
    test_flare_and_landing();
    settle();
    if (mismatch_count == 0 && due_status.size() == 0) begin
      $display("tb_parafoil_deploy_flare_sequencer OK");
    end else begin
      $display("tb_parafoil_deploy_flare_sequencer NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("tb_parafoil_deploy_flare_sequencer NOT OK");
    $finish;
  end

endmodule
